// ----- design/encoder_speed_pid_pwm_macros.svh -----
// assertion macros shared by the speed controller rtl
// every property is clocked on i_clk and disabled while i_rst_n is low
`ifndef ENCODER_SPEED_PID_PWM_MACROS_SVH
`define ENCODER_SPEED_PID_PWM_MACROS_SVH

// same-cycle implication
`define ESPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ESPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/espp_pkg.sv -----
// shared types and constants for the encoder speed controller
// no dependencies
`timescale 1ns / 1ps

package espp_pkg;

    // configuration register map
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I_DT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_OVER_DT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT    = 3'd4;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SETP_W     = 16;
    localparam int unsigned GAIN_W     = 32;
    localparam int unsigned DRIVE_W    = 16;
    localparam int unsigned ISUM_W     = 32;

    // reset values: 2.63, 8.4*0.01 and 0.00015/0.01 in Q16.16, limit 37500
    localparam logic [SETP_W-1:0]  RST_SETPOINT_COUNT = 16'd7200;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P         = 32'd172360;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I_DT      = 32'd5505;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D_OVER_DT = 32'd983;
    localparam logic [DRIVE_W-1:0] RST_OUTPUT_LIMIT   = 16'd37500;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_value;
        logic               clamped;
    } t_drive_res;

endpackage

// ----- design/espp_clamp.sv -----
// magnitude, fraction drop and limit clamp of the controller sum
// depends on espp_pkg
`timescale 1ns / 1ps

module espp_clamp
    import espp_pkg::*;
#(
    parameter int ACC_W          = 66,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic signed [ACC_W-1:0]   i_acc,
    input  logic        [DRIVE_W-1:0] i_limit,
    output t_drive_res                o_res
);

    localparam int Q_W = ACC_W - GAIN_FRAC_BITS;

    logic [ACC_W-1:0] w_mag;
    logic [Q_W-1:0]   w_q;
    logic             w_big;

    // magnitude of the most negative value still fits as unsigned
    assign w_mag = i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
    assign w_q   = w_mag[ACC_W-1:GAIN_FRAC_BITS];
    assign w_big = w_q > Q_W'(i_limit);

    always_comb begin
        o_res.clamped     = w_big;
        o_res.drive_value = w_big ? i_limit : w_q[DRIVE_W-1:0];
    end

endmodule

// ----- design/encoder_speed_pid_pwm.sv -----
// top level of the encoder speed pid controller with pwm compare output
// depends on espp_pkg, espp_clamp and encoder_speed_pid_pwm_macros.svh
`timescale 1ns / 1ps
//
// usage:
//   input channel: i_measured_count with i_in_valid / o_in_stall. one
//   transaction per control period carries the encoder count of that period.
//   output channel: o_drive_value and o_clamped with o_out_valid / i_out_stall.
//   config channel: i_cfg_index / i_cfg_data with i_cfg_valid / o_cfg_ready,
//   ready is always high; write only while no transaction is in flight.
//   throughput: one transaction per clock unless a stall holds the input. the
//   error sum and previous error update in the accepting cycle, so back to
//   back samples need no wait. pipeline: error -> products -> sum -> clamp.
//   stall: each stage holds while the one after it is full and stalled, so
//   up to three more transactions are taken while a result waits at the output.
//   reset: i_rst_n low at a clock edge empties the pipeline, clears the error
//   sum and previous error and loads the default gains, setpoint and limit.
//
`include "encoder_speed_pid_pwm_macros.svh"

module encoder_speed_pid_pwm
    import espp_pkg::*;
#(
    parameter int COUNT_WIDTH    = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COUNT_WIDTH-1:0] i_measured_count,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [DRIVE_W-1:0]     o_drive_value,
    output logic                   o_clamped,
    // config channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int E_W   = COUNT_WIDTH + 1;
    localparam int D_W   = COUNT_WIDTH + 2;
    localparam int PE_W  = E_W + GAIN_W;
    localparam int PS_W  = ISUM_W + GAIN_W;
    localparam int PD_W  = D_W + GAIN_W;
    localparam int ACC_W = ((PD_W > PS_W) ? PD_W : PS_W) + 2;
    localparam int SUM_W = ISUM_W + 2;

    // configuration registers
    logic [SETP_W-1:0]  r_setpoint_count;
    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i_dt;
    logic [GAIN_W-1:0]  r_gain_d_over_dt;
    logic [DRIVE_W-1:0] r_output_limit;

    // controller state
    logic signed [ISUM_W-1:0] r_error_sum;
    logic signed [E_W-1:0]    r_prev_error;
    logic signed [ISUM_W-1:0] n_error_sum;

    // pipeline
    logic                     r_v1, r_v2, r_v3, r_vo;
    logic signed [E_W-1:0]    r_e;
    logic signed [ISUM_W-1:0] r_s;
    logic signed [D_W-1:0]    r_d;
    logic signed [PE_W-1:0]   r_pe;
    logic signed [PS_W-1:0]   r_ps;
    logic signed [PD_W-1:0]   r_pd;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DRIVE_W-1:0]       r_drive_value;
    logic                     r_clamped;

    logic                     w_out_free, w_rdy1, w_rdy2, w_rdy3;
    logic                     w_adv1, w_adv2, w_adv3, w_in_acc;
    logic [CFG_DATA_W-1:0]    w_setp_ext;
    logic [COUNT_WIDTH-1:0]   w_setp;
    logic signed [E_W-1:0]    w_err;
    logic signed [SUM_W-1:0]  w_sum_wide;
    logic signed [D_W-1:0]    w_diff;
    t_drive_res               w_res;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint_count <= RST_SETPOINT_COUNT;
            r_gain_p         <= RST_GAIN_P;
            r_gain_i_dt      <= RST_GAIN_I_DT;
            r_gain_d_over_dt <= RST_GAIN_D_OVER_DT;
            r_output_limit   <= RST_OUTPUT_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SETPOINT_COUNT: r_setpoint_count <= i_cfg_data[SETP_W-1:0];
                CFG_GAIN_P:         r_gain_p         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I_DT:      r_gain_i_dt      <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D_OVER_DT: r_gain_d_over_dt <= i_cfg_data[GAIN_W-1:0];
                CFG_OUTPUT_LIMIT:   r_output_limit   <= i_cfg_data[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign w_out_free = !r_vo || !i_out_stall;
    assign w_rdy3     = !r_v3 || w_out_free;
    assign w_adv3     = r_v3 && w_out_free;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_adv2     = r_v2 && w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign w_adv1     = r_v1 && w_rdy2;
    assign o_in_stall = !w_rdy1;
    assign w_in_acc   = i_in_valid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_in_acc)   r_v1 <= 1'b1;
            else if (w_adv1) r_v1 <= 1'b0;
            if (w_adv1)      r_v2 <= 1'b1;
            else if (w_adv2) r_v2 <= 1'b0;
            if (w_adv2)      r_v3 <= 1'b1;
            else if (w_adv3) r_v3 <= 1'b0;
            if (w_adv3)      r_vo <= 1'b1;
            else if (!i_out_stall) r_vo <= 1'b0;
        end
    end

    // ---------------- error, integral, derivative ----------------
    assign w_setp_ext = CFG_DATA_W'(r_setpoint_count);
    assign w_setp     = w_setp_ext[COUNT_WIDTH-1:0];
    assign w_err      = $signed({1'b0, w_setp}) - $signed({1'b0, i_measured_count});
    assign w_sum_wide = SUM_W'(r_error_sum) + SUM_W'(w_err);
    assign w_diff     = D_W'(w_err) - D_W'(r_prev_error);

    // integral saturates at the signed 32-bit bounds
    always_comb begin
        if (w_sum_wide[SUM_W-1:ISUM_W-1] == '0 || w_sum_wide[SUM_W-1:ISUM_W-1] == '1) begin
            n_error_sum = w_sum_wide[ISUM_W-1:0];
        end else if (w_sum_wide[SUM_W-1]) begin
            n_error_sum = {1'b1, {(ISUM_W-1){1'b0}}};
        end else begin
            n_error_sum = {1'b0, {(ISUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_prev_error <= '0;
        end else if (w_in_acc) begin
            r_error_sum  <= n_error_sum;
            r_prev_error <= w_err;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_e <= w_err;
            r_s <= n_error_sum;
            r_d <= w_diff;
        end
        if (w_adv1) begin
            r_pe <= PE_W'(r_e) * PE_W'($signed({1'b0, r_gain_p}));
            r_ps <= PS_W'(r_s) * PS_W'($signed({1'b0, r_gain_i_dt}));
            r_pd <= PD_W'(r_d) * PD_W'($signed({1'b0, r_gain_d_over_dt}));
        end
        if (w_adv2) begin
            r_acc <= ACC_W'(r_pe) + ACC_W'(r_ps) + ACC_W'(r_pd);
        end
        if (w_adv3) begin
            r_drive_value <= w_res.drive_value;
            r_clamped     <= w_res.clamped;
        end
    end

    espp_clamp #(
        .ACC_W          (ACC_W),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_clamp (
        .i_acc   (r_acc),
        .i_limit (r_output_limit),
        .o_res   (w_res)
    );

    assign o_out_valid   = r_vo;
    assign o_drive_value = r_drive_value;
    assign o_clamped     = r_clamped;

    // ---------------- assertions ----------------
    `ESPP_ASSERT_NEXT(a_prev_error_follows, w_in_acc, r_prev_error == $past(w_err),
        "previous error not updated from accepted transaction")
    `ESPP_ASSERT_NOW(a_empty_stage_no_stall, !r_v1, !o_in_stall,
        "input stalled with first stage empty")
    `ESPP_ASSERT_NOW(a_out_from_stage3, $rose(o_out_valid), $past(r_v3),
        "result appeared without a full sum stage")

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for encoder_speed_pid_pwm
// depends on espp_pkg and the controller rtl; predicts every drive value in-bench
`timescale 1ns / 1ps

module tb;
    import espp_pkg::*;

    localparam int PIPE_LATENCY    = 4;
    localparam int GAIN_FRAC       = 16;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_SHOWN       = 10;
    localparam int WINDUP_UP_STEPS = 24;
    localparam int WINDUP_DN_STEPS = 24;
    localparam int RAND_PHASES     = 12;
    localparam longint ISUM_MAX    = (longint'(1) <<< (ISUM_W - 1)) - 1;
    localparam longint ISUM_MIN    = -(longint'(1) <<< (ISUM_W - 1));
    localparam int IDX_TOP         = (1 << CFG_IDX_W) - 1;

    typedef enum logic [1:0] {CMD_SAMPLE, CMD_REG_WRITE, CMD_DRAIN} t_cmd_kind;

    typedef struct {
        t_cmd_kind              kind;
        logic [SETP_W-1:0]      count;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        bit                     fast;
    } t_ctl_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SETP_W-1:0]     i_measured_count = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DRIVE_W-1:0]    o_drive_value;
    logic                  o_clamped;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_ctl_cmd   pending_q[$];
    t_drive_res drive_expected_q[$];

    // controller copy
    logic [SETP_W-1:0]  ctl_setpoint;
    logic [GAIN_W-1:0]  ctl_gain_p;
    logic [GAIN_W-1:0]  ctl_gain_i;
    logic [GAIN_W-1:0]  ctl_gain_d;
    logic [DRIVE_W-1:0] ctl_output_limit;
    longint             ctl_error_sum;
    longint             ctl_prev_error;

    int  fail_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    logic [SETP_W-1:0] gen_setpoint = RST_SETPOINT_COUNT;

    encoder_speed_pid_pwm uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_measured_count (i_measured_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive_value    (o_drive_value),
        .o_clamped        (o_clamped),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one control period: update the integral and previous error, form the pid sum
    function automatic t_drive_res predict_drive(input logic [SETP_W-1:0] meas);
        longint              err;
        longint              sum_next;
        longint              diff;
        logic signed [127:0] err_w;
        logic signed [127:0] sum_w;
        logic signed [127:0] diff_w;
        logic signed [127:0] acc;
        logic signed [127:0] mag;
        t_drive_res          res;
        err = longint'(ctl_setpoint) - longint'(meas);
        sum_next = ctl_error_sum + err;
        if (sum_next > ISUM_MAX) sum_next = ISUM_MAX;
        else if (sum_next < ISUM_MIN) sum_next = ISUM_MIN;
        diff = err - ctl_prev_error;
        ctl_error_sum = sum_next;
        ctl_prev_error = err;
        err_w = 128'(err);
        sum_w = 128'(sum_next);
        diff_w = 128'(diff);
        acc = err_w * $signed({96'd0, ctl_gain_p})
            + sum_w * $signed({96'd0, ctl_gain_i})
            + diff_w * $signed({96'd0, ctl_gain_d});
        mag = (acc < 0) ? -acc : acc;
        mag = mag >>> GAIN_FRAC;
        if (mag > $signed({112'd0, ctl_output_limit})) begin
            res.drive_value = ctl_output_limit;
            res.clamped = 1'b1;
        end else begin
            res.drive_value = mag[DRIVE_W-1:0];
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SETPOINT_COUNT: ctl_setpoint = data[SETP_W-1:0];
            CFG_GAIN_P:         ctl_gain_p = data[GAIN_W-1:0];
            CFG_GAIN_I_DT:      ctl_gain_i = data[GAIN_W-1:0];
            CFG_GAIN_D_OVER_DT: ctl_gain_d = data[GAIN_W-1:0];
            CFG_OUTPUT_LIMIT:   ctl_output_limit = data[DRIVE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 99);
        if (idx == CFG_SETPOINT_COUNT || idx == CFG_OUTPUT_LIMIT) begin
            if (r < 10) return '0;
            if (r < 25) return 32'h0000_FFFF;
            return $urandom;
        end
        if (r < 15) return '0;
        if (r < 25) return '1;
        if (r < 70) return $urandom_range(0, 32'h0004_0000);
        return $urandom;
    endfunction

    task automatic push_sample(input logic [SETP_W-1:0] cnt, input bit fast);
        t_ctl_cmd c;
        c.kind = CMD_SAMPLE;
        c.count = cnt;
        c.idx = '0;
        c.data = '0;
        c.fast = fast;
        pending_q.push_back(c);
    endtask

    task automatic push_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        t_ctl_cmd c;
        c.kind = CMD_REG_WRITE;
        c.count = '0;
        c.idx = idx;
        c.data = data;
        c.fast = 1'b0;
        pending_q.push_back(c);
        if (idx == CFG_SETPOINT_COUNT) gen_setpoint = data[SETP_W-1:0];
    endtask

    task automatic push_drain();
        t_ctl_cmd c;
        c.kind = CMD_DRAIN;
        c.count = '0;
        c.idx = '0;
        c.data = '0;
        c.fast = 1'b0;
        pending_q.push_back(c);
    endtask

    // driver: samples and register writes, register writes only with the pipe empty
    always @(posedge i_clk) begin
        logic     nxt_in;
        logic     nxt_cfg;
        t_ctl_cmd head;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            ctl_setpoint = RST_SETPOINT_COUNT;
            ctl_gain_p = RST_GAIN_P;
            ctl_gain_i = RST_GAIN_I_DT;
            ctl_gain_d = RST_GAIN_D_OVER_DT;
            ctl_output_limit = RST_OUTPUT_LIMIT;
            ctl_error_sum = 0;
            ctl_prev_error = 0;
        end else begin
            nxt_in = i_in_valid;
            nxt_cfg = i_cfg_valid;
            if (i_in_valid && !o_in_stall) begin
                drive_expected_q.push_back(predict_drive(i_measured_count));
                nxt_in = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
                nxt_cfg = 1'b0;
            end
            if (!nxt_in && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    head = pending_q[0];
                    case (head.kind)
                        CMD_SAMPLE: begin
                            i_measured_count <= head.count;
                            nxt_in = 1'b1;
                            void'(pending_q.pop_front());
                            if (head.fast) calm = 1'b1;
                            else if ($urandom_range(0, 39) == 0) calm = !calm;
                            gap_left = pick_gap();
                        end
                        CMD_REG_WRITE: begin
                            if (drive_expected_q.size() == 0) begin
                                i_cfg_index <= head.idx;
                                i_cfg_data <= head.data;
                                nxt_cfg = 1'b1;
                                void'(pending_q.pop_front());
                            end
                        end
                        default: begin
                            if (drive_expected_q.size() == 0) void'(pending_q.pop_front());
                        end
                    endcase
                end
            end
            i_in_valid <= nxt_in;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // monitor: check each drive transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_drive_res want;
        int         r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (drive_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("unexpected drive transaction: value %0d clamped %0b",
                                 o_drive_value, o_clamped);
                end else begin
                    want = drive_expected_q.pop_front();
                    if (o_drive_value !== want.drive_value || o_clamped !== want.clamped) begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                            $display("drive mismatch: expected value %0d clamped %0b, got value %0d clamped %0b",
                                     want.drive_value, want.clamped, o_drive_value, o_clamped);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (calm || r < 70) begin
                    i_out_stall <= 1'b0;
                end else begin
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int r;
        logic [CFG_IDX_W-1:0] idx;

        // directed: field extremes, zero error, negative sum
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(RST_SETPOINT_COUNT, 1'b0);
        push_sample(RST_SETPOINT_COUNT, 1'b0);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hAAAA, 1'b0);
        push_sample(RST_SETPOINT_COUNT - 16'd1, 1'b0);
        push_sample(RST_SETPOINT_COUNT + 16'd1, 1'b0);
        // zero limit, with and without a nonzero magnitude
        push_reg_write(CFG_OUTPUT_LIMIT, '0);
        push_sample(16'h0000, 1'b0);
        push_reg_write(CFG_GAIN_P, '0);
        push_reg_write(CFG_GAIN_I_DT, '0);
        push_reg_write(CFG_GAIN_D_OVER_DT, '0);
        push_sample(16'h1234, 1'b0);
        // huge sums against the widest limit
        push_reg_write(CFG_OUTPUT_LIMIT, 32'hFFFF_FFFF);
        push_reg_write(CFG_GAIN_P, '1);
        push_reg_write(CFG_GAIN_I_DT, '1);
        push_reg_write(CFG_GAIN_D_OVER_DT, '1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_reg_write(CFG_SETPOINT_COUNT, '0);
        push_sample(16'hFFFF, 1'b0);
        push_reg_write(CFG_SETPOINT_COUNT, '1);
        push_sample(16'h0000, 1'b0);
        // writes to unmapped indexes must not land anywhere
        for (int k = CFG_OUTPUT_LIMIT + 1; k <= IDX_TOP; k++)
            push_reg_write(k[CFG_IDX_W-1:0], '0);
        push_sample(16'h8000, 1'b0);
        push_reg_write(CFG_SETPOINT_COUNT, CFG_DATA_W'(RST_SETPOINT_COUNT));
        push_reg_write(CFG_GAIN_P, RST_GAIN_P);
        push_reg_write(CFG_GAIN_I_DT, RST_GAIN_I_DT);
        push_reg_write(CFG_GAIN_D_OVER_DT, RST_GAIN_D_OVER_DT);
        push_reg_write(CFG_OUTPUT_LIMIT, CFG_DATA_W'(RST_OUTPUT_LIMIT));
        push_sample(16'h0001, 1'b0);
        push_drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int k = CFG_SETPOINT_COUNT; k <= CFG_OUTPUT_LIMIT; k++) begin
                if ($urandom_range(0, 99) < 60)
                    push_reg_write(k[CFG_IDX_W-1:0], pick_reg_value(k[CFG_IDX_W-1:0]));
            end
            if ($urandom_range(0, 99) < 25) begin
                idx = CFG_IDX_W'(CFG_OUTPUT_LIMIT + 1
                      + $urandom_range(0, IDX_TOP - CFG_OUTPUT_LIMIT - 1));
                push_reg_write(idx, $urandom);
            end
            n = $urandom_range(40, 62);
            for (int j = 0; j < n; j++) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    push_sample(gen_setpoint + 16'($urandom_range(0, 400)) - 16'd200, 1'b0);
                else if (r < 85)
                    push_sample(16'($urandom), 1'b0);
                else if (r < 95)
                    push_sample(($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000, 1'b0);
                else
                    push_drain();
            end
        end

        // long one-sided error runs through the integral path, up then down
        push_reg_write(CFG_GAIN_P, '0);
        push_reg_write(CFG_GAIN_I_DT, 32'd1);
        push_reg_write(CFG_GAIN_D_OVER_DT, '0);
        push_reg_write(CFG_OUTPUT_LIMIT, 32'h0000_FFFF);
        push_reg_write(CFG_SETPOINT_COUNT, 32'h0000_FFFF);
        for (int j = 0; j < WINDUP_UP_STEPS; j++) push_sample(16'h0000, 1'b1);
        push_reg_write(CFG_SETPOINT_COUNT, '0);
        for (int j = 0; j < WINDUP_DN_STEPS; j++) push_sample(16'hFFFF, 1'b1);
        push_reg_write(CFG_GAIN_I_DT, '1);
        push_reg_write(CFG_GAIN_P, pick_reg_value(CFG_GAIN_P));
        for (int j = 0; j < 8; j++) push_sample(16'($urandom), 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || i_in_valid || i_cfg_valid || drive_expected_q.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        fail_count += drive_expected_q.size();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/espp_pkg.sv
design/espp_clamp.sv
design/encoder_speed_pid_pwm.sv
tb/sv/tb.sv
